// ===== src/lrp_pkg.sv =====
`default_nettype none

package lrp_pkg;

	localparam int NUM_FRAMES = 32;
	localparam int FRAME_W    = 5;
	localparam int SLOT_W     = $clog2(NUM_FRAMES);
	localparam int CNT_W      = 6;

	typedef enum logic [1:0] {
		OP_VICTIM = 2'd0,
		OP_PIN    = 2'd1,
		OP_UNPIN  = 2'd2
	} op_t;

	// operation presented to the order tracker, valid only when it commits
	typedef struct packed {
		logic               valid;
		logic [1:0]         op;
		logic [FRAME_W-1:0] frame;
	} lrp_req_t;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] victim_frame;
		logic [CNT_W-1:0]   tracked_count;
	} lrp_rsp_t;

endpackage

`default_nettype wire

// ===== src/lrp_order.sv =====
`default_nettype none

module lrp_order (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lrp_pkg::lrp_req_t req,
	output      lrp_pkg::lrp_rsp_t rsp
);
	import lrp_pkg::*;

	logic [FRAME_W-1:0] order_q [NUM_FRAMES];
	logic [FRAME_W-1:0] order_d [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] tracked_q;
	logic [NUM_FRAMES-1:0] tracked_d;
	logic [CNT_W-1:0]      occ_q;
	logic [CNT_W-1:0]      occ_d;

	logic [NUM_FRAMES-1:0] match;
	logic [NUM_FRAMES-1:0] hit_mask;
	logic [NUM_FRAMES-1:0] shift_mask;
	logic [SLOT_W-1:0]     tail_idx;
	logic [SLOT_W-1:0]     frame_idx;
	logic [SLOT_W-1:0]     head_idx;
	logic                  frame_ok;
	logic                  is_victim;
	logic                  is_pin;
	logic                  is_unpin;
	logic                  do_victim;
	logic                  do_pin;
	logic                  do_unpin;

	assign frame_ok  = (32'(req.frame) < NUM_FRAMES);
	assign frame_idx = SLOT_W'(req.frame);
	assign head_idx  = SLOT_W'(order_q[0]);
	assign tail_idx  = occ_q[SLOT_W-1:0];

	always_comb begin
		is_victim = 1'b0;
		is_pin    = 1'b0;
		is_unpin  = 1'b0;
		case (op_t'(req.op))
			OP_VICTIM: is_victim = 1'b1;
			OP_PIN:    is_pin    = 1'b1;
			OP_UNPIN:  is_unpin  = 1'b1;
			default:   ;
		endcase
	end

	assign do_victim = req.valid && is_victim && (occ_q != '0);
	assign do_pin    = req.valid && is_pin && frame_ok && tracked_q[frame_idx];
	assign do_unpin  = req.valid && is_unpin && frame_ok && !tracked_q[frame_idx]
		&& (32'(occ_q) < NUM_FRAMES);

	// parallel match; on a pin, slots at and above the hit close the gap; a victim shifts every slot
	for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_slot
		assign match[k]    = (order_q[k] == req.frame);
		assign hit_mask[k] = |match[k:0];
		assign shift_mask[k] = do_victim || (do_pin && hit_mask[k]);

		if (k == NUM_FRAMES - 1) begin : g_last
			always_comb begin
				order_d[k] = order_q[k];
				if (do_unpin && tail_idx == SLOT_W'(k)) begin
					order_d[k] = req.frame;
				end
			end
		end else begin : g_mid
			always_comb begin
				order_d[k] = shift_mask[k] ? order_q[k+1] : order_q[k];
				if (do_unpin && tail_idx == SLOT_W'(k)) begin
					order_d[k] = req.frame;
				end
			end
		end
	end

	always_comb begin
		tracked_d = tracked_q;
		occ_d     = occ_q;
		if (do_victim) begin
			tracked_d[head_idx] = 1'b0;
			occ_d = occ_q - CNT_W'(1);
		end
		if (do_pin) begin
			tracked_d[frame_idx] = 1'b0;
			occ_d = occ_q - CNT_W'(1);
		end
		if (do_unpin) begin
			tracked_d[frame_idx] = 1'b1;
			occ_d = occ_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			order_q <= order_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= '0;
			occ_q     <= '0;
		end else if (req.valid) begin
			tracked_q <= tracked_d;
			occ_q     <= occ_d;
		end
	end

	assign rsp.found         = do_victim;
	assign rsp.victim_frame  = do_victim ? order_q[0] : '0;
	assign rsp.tracked_count = occ_d;

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= NUM_FRAMES)
		else $error("occupancy above capacity");

	a_flags_match_occ: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tracked_q) == 32'(occ_q))
		else $error("tracked flags disagree with occupancy");

	a_victim_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		do_victim |=> occ_q == $past(occ_q) - CNT_W'(1))
		else $error("victim did not remove exactly one frame");

	a_unpin_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		do_unpin |=> tracked_q[$past(frame_idx)])
		else $error("unpinned frame not tracked");
`endif

endmodule

`default_nettype wire

// ===== src/lru_replacer_pin_unpin.sv =====
`default_nettype none

// lru replacement tracker with pinning for a buffer pool of NUM_FRAMES frames
//
// input channel: operation (victim request, pin, unpin) and frame, moved by
//   in_valid / in_stall; a transfer happens when in_valid is high and in_stall low
// output channel: found, victim_frame, tracked_count, moved by out_valid /
//   out_stall; exactly one result per input transfer, in order
// path: each operation is held in the input register, then its result in the
//   result register, until the result transfer
// throughput: one operation per cycle while the output is not stalled; the whole
//   update (parallel frame match, gap-closing shift of the recency slots, flag and
//   count update) fits between the input register and the result register
// stall: while out_stall holds a waiting result, one more operation may sit in
//   the input register; in_stall rises only when both are full
// reset: arst_n clears the tracked flags, the count and both valid bits; the
//   recency slots are not cleared, since only slots below the count are read
// unused operation code and out-of-range frames change nothing and report the count

module lru_replacer_pin_unpin (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input channel
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic [1:0]                  operation,
	input  wire logic [lrp_pkg::FRAME_W-1:0] frame,
	// output channel
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic                        found,
	output      logic [lrp_pkg::FRAME_W-1:0] victim_frame,
	output      logic [lrp_pkg::CNT_W-1:0]   tracked_count
);
	import lrp_pkg::*;

	// input register stage
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic               advance;

	// result register
	logic               res_valid_q;
	lrp_rsp_t           res_q;

	lrp_req_t           req;
	lrp_rsp_t           rsp;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= operation;
			frame_s1 <= frame;
		end
	end

	// the operation commits to the state only in the cycle it moves to the result
	assign req.valid = valid_s1 && advance;
	assign req.op    = op_s1;
	assign req.frame = frame_s1;

	lrp_order u_order (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			res_q <= rsp;
		end
	end

	assign out_valid     = res_valid_q;
	assign found         = res_q.found;
	assign victim_frame  = res_q.victim_frame;
	assign tracked_count = res_q.tracked_count;

`ifndef ASSERT_OFF
	a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && out_stall |=> res_valid_q && $stable(res_q))
		else $error("stalled result changed or dropped");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with free space");

	a_victim_reports_found: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && rsp.found |-> rsp.tracked_count < CNT_W'(NUM_FRAMES))
		else $error("victim found with full count");
`endif

endmodule

`default_nettype wire
